// File: hdl/bwum_pkg.sv
`timescale 1ns / 1ps

package bwum_pkg;

  // Default values for the top level parameters
  localparam int unsigned CounterBitsDef  = 32;
  localparam int unsigned PctFracBitsDef  = 8;

  // Fixed field widths
  localparam int unsigned DataW   = 32;
  localparam int unsigned WinW    = 16;
  localparam int unsigned BusyW   = 48;
  localparam int unsigned PctW    = 15;
  localparam int unsigned OpW     = 2;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned MsPerS  = 1000;
  localparam int unsigned PctFull = 100;

  // Register reset values
  localparam logic [DataW-1:0] ClockRateRst = 32'd100000000;
  localparam logic [WinW-1:0]  WindowLenRst = 16'd1000;

  typedef enum logic [OpW-1:0] {
    OP_LOOP_BEGIN = 2'd0,
    OP_LOOP_END   = 2'd1,
    OP_WIN_CHECK  = 2'd2,
    OP_RSVD       = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLOCK_RATE = 2'd0,
    CFG_WINDOW_LEN = 2'd1,
    CFG_RAM_TOTAL  = 2'd2,
    CFG_STACK_TOP  = 2'd3
  } cfg_idx_e;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MUL   = 7'b0000010,
    S_CHECK = 7'b0000100,
    S_LOAD  = 7'b0001000,
    S_DIV   = 7'b0010000,
    S_STORE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

endpackage

// File: hdl/busy_window_utilization_monitor_core.sv
`timescale 1ns / 1ps

// Busy-window utilization monitor. Loop begin and loop end events are taken
// while the block stays idle (in_stall_o stays low). A window check that finds
// the window still open goes through S_MUL and S_CHECK back to idle; when it
// closes, one restoring divider is used twice (busy percent, then stack
// percent), QB = clog2(100*2^FRAC + 1) steps per pass (15 at the default 8
// fraction bits), and the result waits in S_OUT for the previous one to be
// taken. Inputs stall for the whole check. Percentages are fixed point with
// PERCENT_FRACTION_BITS fraction bits, truncated and capped at 100 percent.
module busy_window_utilization_monitor_core #(
  parameter int unsigned COUNTER_BITS          = bwum_pkg::CounterBitsDef,
  parameter int unsigned PERCENT_FRACTION_BITS = bwum_pkg::PctFracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             cfg_we_i,
  input  logic [bwum_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [bwum_pkg::DataW-1:0]       cfg_wdata_i,

  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [bwum_pkg::OpW-1:0]         operation_i,
  input  logic [bwum_pkg::DataW-1:0]       cycle_count_i,
  input  logic [bwum_pkg::DataW-1:0]       stack_pointer_i,

  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [bwum_pkg::PctW-1:0]        cpu_busy_percent_o,
  output logic [bwum_pkg::DataW-1:0]       stack_used_bytes_o,
  output logic [bwum_pkg::PctW-1:0]        stack_use_percent_o
);

  localparam int unsigned DataW = bwum_pkg::DataW;
  localparam int unsigned BusyW = bwum_pkg::BusyW;
  localparam int unsigned PctW  = bwum_pkg::PctW;
  localparam int unsigned WinW  = bwum_pkg::WinW;
  // counter sample is at most as wide as the input field
  localparam int unsigned CntW  = (COUNTER_BITS < DataW) ? COUNTER_BITS : DataW;
  localparam int unsigned FullPct = bwum_pkg::PctFull << PERCENT_FRACTION_BITS;
  localparam int unsigned QB    = $clog2(FullPct + 1);
  localparam int unsigned ProdW = DataW + QB;
  localparam int unsigned CntQW = $clog2(QB + 1);
  localparam int unsigned NeedW = WinW + DataW;
  localparam logic [BusyW-1:0] BusyMax  = {BusyW{1'b1}};
  localparam logic [QB-1:0]    FullQ    = QB'(FullPct);
  localparam logic [NeedW-1:0] MsPerSW  = NeedW'(bwum_pkg::MsPerS);

  // configuration
  logic [DataW-1:0] clock_rate_q, ram_total_q, stack_top_q;
  logic [WinW-1:0]  window_len_q;

  // block state
  logic [CntW-1:0]  window_start_q, loop_start_q;
  logic [BusyW-1:0] busy_total_q, busy_total_d;

  bwum_pkg::state_e state_q, state_d;

  // per-check working registers
  logic [CntW-1:0]  now_q, now_d;
  logic [DataW-1:0] sp_q, sp_d;
  logic [CntW-1:0]  elapsed_q, elapsed_d;
  logic [NeedW-1:0] need_q, need_d;
  logic [DataW-1:0] used_q, used_d;
  logic             pass_q, pass_d;
  logic [DataW-1:0] den_q, den_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [QB-1:0]    quo_q, quo_d;
  logic [CntQW-1:0] cnt_q, cnt_d;
  logic [PctW-1:0]  busy_pct_q, busy_pct_d;

  logic             out_valid_q, out_valid_d;
  logic [PctW-1:0]  out_busy_q, out_busy_d;
  logic [DataW-1:0] out_used_q, out_used_d;
  logic [PctW-1:0]  out_stack_q, out_stack_d;

  logic [CntW-1:0]  loop_start_d, window_start_d;

  logic             in_xfer;
  logic [CntW-1:0]  in_now;
  logic [CntW-1:0]  span;

  // load / divide helpers
  logic [BusyW-1:0] ld_num;
  logic [DataW-1:0] ld_den;
  logic [ProdW-1:0] ld_prod;
  logic [NeedW-1:0] elapsed_ms_x;
  logic             reached;
  logic [DataW:0]   div_t;
  logic             div_ge;

  assign in_stall_o = (state_q != bwum_pkg::S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign in_now     = cycle_count_i[CntW-1:0];
  assign span       = in_now - loop_start_q;

  assign out_valid_o         = out_valid_q;
  assign cpu_busy_percent_o  = out_busy_q;
  assign stack_used_bytes_o  = out_used_q;
  assign stack_use_percent_o = out_stack_q;

  // window reached: elapsed*1000 >= window*clock, same as the ceil threshold
  assign elapsed_ms_x = NeedW'(elapsed_q) * MsPerSW;
  assign reached = (clock_rate_q == '0) ? (window_len_q == '0) : (elapsed_ms_x >= need_q);

  assign ld_num  = pass_q ? BusyW'(used_q) : busy_total_q;
  assign ld_den  = pass_q ? ram_total_q : DataW'(elapsed_q);
  assign ld_prod = ProdW'(ld_num[DataW-1:0]) * ProdW'(FullPct);

  assign div_t  = {rem_q, quo_q[QB-1]};
  assign div_ge = (div_t >= {1'b0, den_q});

  always_comb begin
    state_d        = state_q;
    now_d          = now_q;
    sp_d           = sp_q;
    elapsed_d      = elapsed_q;
    need_d         = need_q;
    used_d         = used_q;
    pass_d         = pass_q;
    den_d          = den_q;
    rem_d          = rem_q;
    quo_d          = quo_q;
    cnt_d          = cnt_q;
    busy_pct_d     = busy_pct_q;
    busy_total_d   = busy_total_q;
    loop_start_d   = loop_start_q;
    window_start_d = window_start_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_busy_d     = out_busy_q;
    out_used_d     = out_used_q;
    out_stack_d    = out_stack_q;

    case (state_q)
      bwum_pkg::S_IDLE: begin
        if (in_xfer) begin
          case (bwum_pkg::op_e'(operation_i))
            bwum_pkg::OP_LOOP_BEGIN: loop_start_d = in_now;
            bwum_pkg::OP_LOOP_END: begin
              // counter went backwards: nothing added
              if (in_now >= loop_start_q) begin
                if (BusyW'(span) >= BusyMax - busy_total_q) begin
                  busy_total_d = BusyMax;
                end else begin
                  busy_total_d = busy_total_q + BusyW'(span);
                end
              end
            end
            bwum_pkg::OP_WIN_CHECK: begin
              now_d   = in_now;
              sp_d    = stack_pointer_i;
              state_d = bwum_pkg::S_MUL;
            end
            default: ;
          endcase
        end
      end
      bwum_pkg::S_MUL: begin
        elapsed_d = (now_q >= window_start_q) ? now_q - window_start_q : '0;
        need_d    = NeedW'(window_len_q) * NeedW'(clock_rate_q);
        used_d    = (stack_top_q > sp_q) ? stack_top_q - sp_q : '0;
        state_d   = bwum_pkg::S_CHECK;
      end
      bwum_pkg::S_CHECK: begin
        pass_d  = 1'b0;
        state_d = reached ? bwum_pkg::S_LOAD : bwum_pkg::S_IDLE;
      end
      bwum_pkg::S_LOAD: begin
        den_d = ld_den;
        if (ld_den == '0) begin
          quo_d   = '0;
          state_d = bwum_pkg::S_STORE;
        end else if (ld_num >= BusyW'(ld_den)) begin
          quo_d   = FullQ;
          state_d = bwum_pkg::S_STORE;
        end else begin
          // top part of num*full is already below den
          rem_d   = ld_prod[ProdW-1:QB];
          quo_d   = ld_prod[QB-1:0];
          cnt_d   = CntQW'(QB);
          state_d = bwum_pkg::S_DIV;
        end
      end
      bwum_pkg::S_DIV: begin
        rem_d = div_ge ? DataW'(div_t - {1'b0, den_q}) : div_t[DataW-1:0];
        quo_d = {quo_q[QB-2:0], div_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CntQW'(1)) begin
          state_d = bwum_pkg::S_STORE;
        end
      end
      bwum_pkg::S_STORE: begin
        if (!pass_q) begin
          busy_pct_d = PctW'(quo_q);
          pass_d     = 1'b1;
          state_d    = bwum_pkg::S_LOAD;
        end else begin
          state_d    = bwum_pkg::S_OUT;
        end
      end
      bwum_pkg::S_OUT: begin
        // hold until the previous result has been taken
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d    = 1'b1;
          out_busy_d     = busy_pct_q;
          out_used_d     = used_q;
          out_stack_d    = PctW'(quo_q);
          window_start_d = now_q;
          busy_total_d   = '0;
          state_d        = bwum_pkg::S_IDLE;
        end
      end
      default: state_d = bwum_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bwum_pkg::S_IDLE;
      out_valid_q    <= 1'b0;
      clock_rate_q   <= bwum_pkg::ClockRateRst;
      window_len_q   <= bwum_pkg::WindowLenRst;
      ram_total_q    <= '0;
      stack_top_q    <= '0;
      window_start_q <= '0;
      loop_start_q   <= '0;
      busy_total_q   <= '0;
      pass_q         <= 1'b0;
      cnt_q          <= '0;
    end else begin
      state_q        <= state_d;
      out_valid_q    <= out_valid_d;
      window_start_q <= window_start_d;
      loop_start_q   <= loop_start_d;
      busy_total_q   <= busy_total_d;
      pass_q         <= pass_d;
      cnt_q          <= cnt_d;
      if (cfg_we_i) begin
        case (bwum_pkg::cfg_idx_e'(cfg_idx_i))
          bwum_pkg::CFG_CLOCK_RATE: clock_rate_q <= cfg_wdata_i;
          bwum_pkg::CFG_WINDOW_LEN: window_len_q <= cfg_wdata_i[WinW-1:0];
          bwum_pkg::CFG_RAM_TOTAL:  ram_total_q  <= cfg_wdata_i;
          bwum_pkg::CFG_STACK_TOP:  stack_top_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    now_q       <= now_d;
    sp_q        <= sp_d;
    elapsed_q   <= elapsed_d;
    need_q      <= need_d;
    used_q      <= used_d;
    den_q       <= den_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    busy_pct_q  <= busy_pct_d;
    out_busy_q  <= out_busy_d;
    out_used_q  <= out_used_d;
    out_stack_q <= out_stack_d;
  end

endmodule

// File: test/busy_window_utilization_monitor_core_tb.sv
`timescale 1ns / 1ps

module busy_window_utilization_monitor_core_tb;

  localparam int unsigned DataW   = bwum_pkg::DataW;
  localparam int unsigned WinW    = bwum_pkg::WinW;
  localparam int unsigned BusyW   = bwum_pkg::BusyW;
  localparam int unsigned PctW    = bwum_pkg::PctW;
  localparam int unsigned OpW     = bwum_pkg::OpW;
  localparam int unsigned CfgIdxW = bwum_pkg::CfgIdxW;
  localparam int unsigned MsPerS  = bwum_pkg::MsPerS;

  localparam int unsigned SettleCycles = 64;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned BurstEnds    = 24;
  localparam int unsigned ItemTarget   = 1250;
  localparam int unsigned MinReports   = 48;

  localparam logic [BusyW-1:0] BusyMax = {BusyW{1'b1}};
  localparam longint unsigned  FullPct = 64'(bwum_pkg::PctFull) << bwum_pkg::PctFracBitsDef;

  typedef struct packed {
    logic [PctW-1:0]  busy_pct;
    logic [DataW-1:0] used_bytes;
    logic [PctW-1:0]  use_pct;
  } window_report_t;

  typedef enum logic {ROW_CFG, ROW_EVENT} row_kind_e;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_FIXED} chk_e;

  typedef struct {
    row_kind_e        kind;
    logic [DataW-1:0] clock_hz;
    logic [WinW-1:0]  window_ms;
    logic [DataW-1:0] ram_bytes;
    logic [DataW-1:0] stack_top;
    bwum_pkg::op_e    op;
    logic [DataW-1:0] cnt;
    logic [DataW-1:0] sp;
    chk_e             chk;
    window_report_t   fixed;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni          = 1'b0;
  logic                 cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i       = bwum_pkg::CFG_CLOCK_RATE;
  logic [DataW-1:0]     cfg_wdata_i     = '0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic [OpW-1:0]       operation_i     = bwum_pkg::OP_LOOP_BEGIN;
  logic [DataW-1:0]     cycle_count_i   = '0;
  logic [DataW-1:0]     stack_pointer_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic [PctW-1:0]      cpu_busy_percent_o;
  logic [DataW-1:0]     stack_used_bytes_o;
  logic [PctW-1:0]      stack_use_percent_o;

  // predictor state and its copy of the registers
  logic [DataW-1:0] cfg_clock_hz  = bwum_pkg::ClockRateRst;
  logic [WinW-1:0]  cfg_window_ms = bwum_pkg::WindowLenRst;
  logic [DataW-1:0] cfg_ram_bytes = '0;
  logic [DataW-1:0] cfg_stack_top = '0;
  logic [DataW-1:0] win_mark      = '0;
  logic [DataW-1:0] loop_mark     = '0;
  logic [BusyW-1:0] busy_acc      = '0;

  window_report_t pending_reports[$];
  stim_row_t      directed_rows[$];
  window_report_t no_report   = '0;
  window_report_t got_report;
  window_report_t want_report;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned reports_due    = 0;
  int unsigned reports_seen   = 0;
  int unsigned events_sent    = 0;
  int unsigned random_events  = 0;
  int unsigned quiet_cycles   = 0;

  busy_window_utilization_monitor_core u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .operation_i         (operation_i),
    .cycle_count_i       (cycle_count_i),
    .stack_pointer_i     (stack_pointer_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .cpu_busy_percent_o  (cpu_busy_percent_o),
    .stack_used_bytes_o  (stack_used_bytes_o),
    .stack_use_percent_o (stack_use_percent_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cycles the window must span: ceil(window_ms * clock_hz / 1000)
  function automatic longint unsigned window_threshold(logic [DataW-1:0] clock_hz,
                                                       logic [WinW-1:0] window_ms);
    longint unsigned need;
    need = 64'(window_ms) * 64'(clock_hz);
    return (need + MsPerS - 1) / MsPerS;
  endfunction

  function automatic logic [PctW-1:0] capped_pct(logic [BusyW-1:0] num, logic [DataW-1:0] den);
    longint unsigned q;
    if (den == '0) begin
      q = 0;
    end else if (num >= BusyW'(den)) begin
      q = FullPct;
    end else begin
      q = (64'(num) * FullPct) / 64'(den);
    end
    return q[PctW-1:0];
  endfunction

  // Advances the predictor by one event; returns 1 when a window closes.
  function automatic logic account_event(bwum_pkg::op_e op, logic [DataW-1:0] cnt,
                                         logic [DataW-1:0] sp, output window_report_t rep);
    logic [BusyW-1:0] span;
    logic [DataW-1:0] elapsed;
    logic [DataW-1:0] used;
    logic             reached;
    rep = '0;
    case (op)
      bwum_pkg::OP_LOOP_BEGIN: begin
        loop_mark = cnt;
        return 1'b0;
      end
      bwum_pkg::OP_LOOP_END: begin
        if (cnt >= loop_mark) begin
          span = BusyW'(cnt - loop_mark);
          if (span >= BusyMax - busy_acc) busy_acc = BusyMax;
          else busy_acc = busy_acc + span;
        end
        return 1'b0;
      end
      bwum_pkg::OP_WIN_CHECK: begin
        elapsed = (cnt >= win_mark) ? cnt - win_mark : '0;
        if (cfg_clock_hz == '0) reached = (cfg_window_ms == '0);
        else reached = (64'(elapsed) >= window_threshold(cfg_clock_hz, cfg_window_ms));
        if (!reached) return 1'b0;
        used = (cfg_stack_top > sp) ? cfg_stack_top - sp : '0;
        rep.busy_pct   = capped_pct(busy_acc, elapsed);
        rep.used_bytes = used;
        rep.use_pct    = capped_pct(BusyW'(used), cfg_ram_bytes);
        win_mark = cnt;
        busy_acc = '0;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic void tab_cfg(logic [DataW-1:0] clock_hz, logic [WinW-1:0] window_ms,
                                  logic [DataW-1:0] ram_bytes, logic [DataW-1:0] stack_top);
    stim_row_t r;
    r = '{kind: ROW_CFG, op: bwum_pkg::OP_LOOP_BEGIN, chk: CHK_NONE, default: '0};
    r.clock_hz  = clock_hz;
    r.window_ms = window_ms;
    r.ram_bytes = ram_bytes;
    r.stack_top = stack_top;
    directed_rows.push_back(r);
  endfunction

  function automatic void tab_event(bwum_pkg::op_e op, logic [DataW-1:0] cnt,
                                    logic [DataW-1:0] sp, chk_e chk, logic [PctW-1:0] busy_pct,
                                    logic [DataW-1:0] used_bytes, logic [PctW-1:0] use_pct);
    stim_row_t r;
    r = '{kind: ROW_EVENT, op: op, chk: chk, default: '0};
    r.cnt   = cnt;
    r.sp    = sp;
    r.fixed = '{busy_pct: busy_pct, used_bytes: used_bytes, use_pct: use_pct};
    directed_rows.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("mismatch %s: got 0x%0h want 0x%0h (report %0d, t=%0t)",
             what, got, want, reports_seen, $realtime);
  endtask

  // Returns in the step of the edge at which the transfer happened; valid stays
  // high so a following call can present its payload without a gap.
  task automatic drive_event(bwum_pkg::op_e op, logic [DataW-1:0] cnt, logic [DataW-1:0] sp,
                             chk_e chk, window_report_t fixed);
    window_report_t rep;
    logic           closes;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    cycle_count_i   <= cnt;
    stack_pointer_i <= sp;
    do @(posedge clk_i); while (in_stall_o);
    events_sent++;
    closes = account_event(op, cnt, sp, rep);
    case (chk)
      CHK_PREDICT: if (closes) begin
        pending_reports.push_back(rep);
        reports_due++;
      end
      CHK_FIXED: begin
        pending_reports.push_back(fixed);
        reports_due++;
      end
      default: ;
    endcase
  endtask

  task automatic put_reg(bwum_pkg::cfg_idx_e idx, logic [DataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // Registers change only with the block idle and every report collected.
  task automatic set_config(logic [DataW-1:0] clock_hz, logic [WinW-1:0] window_ms,
                            logic [DataW-1:0] ram_bytes, logic [DataW-1:0] stack_top);
    logic [DataW-1:0] junk;
    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    junk = $urandom;
    put_reg(bwum_pkg::CFG_CLOCK_RATE, clock_hz);
    // upper bits of the window write are don't-care
    put_reg(bwum_pkg::CFG_WINDOW_LEN, {junk[DataW-1:WinW], window_ms});
    put_reg(bwum_pkg::CFG_RAM_TOTAL, ram_bytes);
    put_reg(bwum_pkg::CFG_STACK_TOP, stack_top);
    cfg_we_i <= 1'b0;
    cfg_clock_hz  = clock_hz;
    cfg_window_ms = window_ms;
    cfg_ram_bytes = ram_bytes;
    cfg_stack_top = stack_top;
  endtask

  // Mostly begin/end pairs on a forward-running counter with window checks
  // between them; the rest is random noise, reserved ops included.
  task automatic run_phase(int unsigned n, int unsigned min_reports, logic [DataW-1:0] clock_hz,
                           logic [WinW-1:0] window_ms, logic [DataW-1:0] ram_bytes,
                           logic [DataW-1:0] stack_top);
    longint unsigned  thr;
    logic [DataW-1:0] scale;
    logic [DataW-1:0] tnow;
    logic [DataW-1:0] sp;
    int unsigned      done;
    set_config(clock_hz, window_ms, ram_bytes, stack_top);
    thr = window_threshold(clock_hz, window_ms);
    if ((clock_hz == '0 && window_ms != '0) || thr > 64'h4000_0000) scale = 32'h0100_0000;
    else scale = DataW'(thr / 2 + 1);
    tnow = win_mark;
    done = 0;
    while (done < n || (reports_due < min_reports && done < n + 2000)) begin
      if ($urandom_range(0, 99) < 15) begin
        drive_event(bwum_pkg::op_e'($urandom_range(0, 3)), $urandom, $urandom, CHK_PREDICT,
                    no_report);
        done++;
      end else begin
        if (tnow < win_mark) tnow = win_mark;
        drive_event(bwum_pkg::OP_LOOP_BEGIN, tnow, $urandom, CHK_PREDICT, no_report);
        tnow = tnow + $urandom_range(0, scale);
        drive_event(bwum_pkg::OP_LOOP_END, tnow, $urandom, CHK_PREDICT, no_report);
        tnow = tnow + $urandom_range(0, scale);
        done += 2;
        if ($urandom_range(0, 99) < 45) begin
          sp = $urandom_range(0, 1) ? $urandom : cfg_stack_top - $urandom_range(0, cfg_ram_bytes);
          drive_event(bwum_pkg::OP_WIN_CHECK, tnow, sp, CHK_PREDICT, no_report);
          done++;
        end
      end
    end
    random_events += done;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_report = '{busy_pct: cpu_busy_percent_o, used_bytes: stack_used_bytes_o,
                     use_pct: stack_use_percent_o};
      if (pending_reports.size() == 0) begin
        report_mismatch("report with none pending", 64'(got_report.used_bytes), 64'd0);
      end else begin
        want_report = pending_reports.pop_front();
        if (got_report.busy_pct != want_report.busy_pct)
          report_mismatch("cpu_busy_percent", 64'(got_report.busy_pct),
                          64'(want_report.busy_pct));
        if (got_report.used_bytes != want_report.used_bytes)
          report_mismatch("stack_used_bytes", 64'(got_report.used_bytes),
                          64'(want_report.used_bytes));
        if (got_report.use_pct != want_report.use_pct)
          report_mismatch("stack_use_percent", 64'(got_report.use_pct),
                          64'(want_report.use_pct));
      end
      reports_seen++;
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // watchdog: no transfer on either side for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("timeout: no transfer for %0d cycles, %0d reports pending",
               StallLimit, pending_reports.size());
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned burst_events;

    // reset values: 100 MHz clock, 1000 ms window, no RAM size, stack top at 0
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'd99999999, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'd100000000, 32'hFFFF_FFFF, CHK_FIXED, 0, 0, 0);
    tab_event(bwum_pkg::OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CHK_NONE, 0, 0, 0);
    // 1 kHz clock, 10 ms window
    tab_cfg(32'd1000, 16'd10, 32'd4096, 32'h2000_0000);
    tab_event(bwum_pkg::OP_LOOP_BEGIN, 32'd100000010, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_LOOP_END, 32'd100000005, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_LOOP_END, 32'd100000030, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'd100000020, 32'h1FFF_F800, CHK_FIXED, 15'd25600,
              32'd2048, 15'd12800);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'd100000029, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'd5, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_LOOP_BEGIN, 32'd100000030, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_LOOP_END, 32'd100000035, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'd100000060, 32'h2000_0000, CHK_FIXED, 15'd3200, 0, 0);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'd100000070, 32'h0, CHK_FIXED, 0, 32'h2000_0000,
              15'd25600);
    // 1.5 kHz clock: an elapsed count of one is short of a 1 ms window, two is not
    tab_cfg(32'd1500, 16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'd100000071, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'd100000072, 32'h0, CHK_FIXED, 0, 32'hFFFF_FFFF,
              15'd25600);
    // zero clock and zero window: every check closes
    tab_cfg(32'h0, 16'h0, 32'h0, 32'hFFFF_FFFF);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'd100000072, 32'h1, CHK_FIXED, 0, 32'hFFFF_FFFE, 0);
    tab_event(bwum_pkg::OP_LOOP_BEGIN, 32'h0, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_LOOP_END, 32'hFFFF_FFFF, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CHK_FIXED, 15'd25600, 0, 0);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'h0, 32'h0, CHK_FIXED, 0, 32'hFFFF_FFFF, 0);
    // zero clock with a nonzero window never closes
    tab_cfg(32'h0, 16'd1, 32'd1, 32'h8000_0000);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'h10, 32'h0, CHK_NONE, 0, 0, 0);
    tab_event(bwum_pkg::OP_RSVD, 32'h0, 32'h0, CHK_NONE, 0, 0, 0);
    tab_cfg(32'hFFFF_FFFF, 16'hFFFF, 32'd3, 32'h8000_0000);
    tab_event(bwum_pkg::OP_WIN_CHECK, 32'hFFFF_FFFF, 32'h0, CHK_NONE, 0, 0, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct  = 26;
    recv_stall_pct = 61;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        set_config(directed_rows[i].clock_hz, directed_rows[i].window_ms,
                   directed_rows[i].ram_bytes, directed_rows[i].stack_top);
      else
        drive_event(directed_rows[i].op, directed_rows[i].cnt, directed_rows[i].sp,
                    directed_rows[i].chk, directed_rows[i].fixed);
    end

    run_phase(280, 0, 32'd1000, 16'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_phase(50, 0, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 32'h0);

    send_idle_pct  = 61;
    recv_stall_pct = 26;
    run_phase(280, 0, $urandom_range(1000, 1000000), WinW'($urandom_range(1, 50)),
              $urandom, $urandom);
    run_phase(150, 0, 32'h0, 16'h0, $urandom, $urandom);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_phase(250, 0, bwum_pkg::ClockRateRst, 16'd1, $urandom, $urandom);

    // pile full-range spans into the busy accumulator, then read it out over a
    // full-range window; a sum kept to 32 bits would show below 100 percent
    set_config(32'h0, 16'h0, $urandom, $urandom);
    burst_events = events_sent;
    drive_event(bwum_pkg::OP_WIN_CHECK, 32'h0, $urandom, CHK_PREDICT, no_report);
    drive_event(bwum_pkg::OP_LOOP_BEGIN, 32'h0, $urandom, CHK_PREDICT, no_report);
    repeat (BurstEnds)
      drive_event(bwum_pkg::OP_LOOP_END, 32'hFFFF_FFFF, $urandom, CHK_PREDICT, no_report);
    drive_event(bwum_pkg::OP_WIN_CHECK, 32'hFFFF_FFFF, $urandom, CHK_PREDICT, no_report);
    burst_events = events_sent - burst_events;

    run_phase((random_events < ItemTarget) ? ItemTarget - random_events : 0, MinReports,
              $urandom_range(1, 2000000), WinW'($urandom_range(0, 100)), $urandom, $urandom);

    in_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("%0d events (%0d random, %0d in the wide accumulation burst)",
             events_sent, random_events, burst_events);
    $display("%0d window reports checked, %0d mismatches", reports_seen, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/bwum_pkg.sv
hdl/busy_window_utilization_monitor_core.sv
test/busy_window_utilization_monitor_core_tb.sv
